FILE: rtl/vcpi_pkg.sv
package vcpi_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int IDX_W = $clog2(PALETTE_DEPTH);
	localparam int NFE_W = $clog2(PALETTE_DEPTH + 1);
	localparam int COLOR_W = 32;
	localparam int MAT_W = 8;
	localparam int POS_W = 24;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		logic               start;
		logic               skip;
	} vcpi_req_t;

	typedef struct packed {
		logic             done;
		logic             filled;
		logic [IDX_W-1:0] mat;
		logic             ovf_set;
	} vcpi_rsp_t;

	function automatic logic [COLOR_W-1:0] to_rgba(input logic [COLOR_W-1:0] c);
		return {c[31:24], c[7:0], c[15:8], c[23:16]};
	endfunction

endpackage

FILE: rtl/vcpi_if.sv
interface vcpi_in_if;
	import vcpi_pkg::*;

	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] voxel_color;
	logic               matrix_start;

	modport source (output valid, output voxel_color, output matrix_start, input ready);
	modport sink (input valid, input voxel_color, input matrix_start, output ready);
endinterface

interface vcpi_out_if;
	import vcpi_pkg::*;

	logic             valid;
	logic             ready;
	logic             voxel_filled;
	logic [MAT_W-1:0] material_index;
	logic [POS_W-1:0] voxel_position;
	logic             palette_overflow;

	modport source (output valid, output voxel_filled, output material_index,
		output voxel_position, output palette_overflow, input ready);
	modport sink (input valid, input voxel_filled, input material_index,
		input voxel_position, input palette_overflow, output ready);
endinterface

FILE: rtl/vcpi_search.sv
module vcpi_search
	import vcpi_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  vcpi_req_t req,
	input  logic      take,
	output vcpi_rsp_t rsp
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [COLOR_W-1:0] color_q;
	logic [NFE_W-1:0]   nfe_q;
	logic [NFE_W-1:0]   idx_q;
	logic [IDX_W-1:0]   idx_s1;
	logic               v_s1;
	logic [COLOR_W-1:0] rdata_s1;
	logic               filled_q;
	logic [IDX_W-1:0]   mat_q;
	logic               ovf_q;

	logic [COLOR_W-1:0] mem [PALETTE_DEPTH];

	logic hit;
	logic scan_end;
	logic full;
	logic issue;
	logic wr_en;
	logic rd_en;

	always_comb begin
		hit      = v_s1 && (rdata_s1 == color_q);
		scan_end = !v_s1 && (idx_q >= nfe_q);
		full     = nfe_q == NFE_W'(PALETTE_DEPTH);
		issue    = idx_q < nfe_q;
		wr_en    = (state_q == S_SCAN) && !hit && scan_end && !full;
		rd_en    = (state_q == S_SCAN) && !hit && !scan_end && issue;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[nfe_q[IDX_W-1:0]] <= color_q;
		end
		if (rd_en) begin
			rdata_s1 <= mem[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			color_q  <= '0;
			nfe_q    <= NFE_W'(1);
			idx_q    <= '0;
			idx_s1   <= '0;
			v_s1     <= 1'b0;
			filled_q <= 1'b0;
			mat_q    <= '0;
			ovf_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						color_q <= req.color;
						if (req.start) begin
							nfe_q <= NFE_W'(1);
						end
						if (req.skip) begin
							filled_q <= 1'b0;
							mat_q    <= '0;
							ovf_q    <= 1'b0;
							state_q  <= S_DONE;
						end else begin
							idx_q   <= NFE_W'(1);
							v_s1    <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						filled_q <= 1'b1;
						mat_q    <= idx_s1;
						ovf_q    <= 1'b0;
						v_s1     <= 1'b0;
						state_q  <= S_DONE;
					end else if (scan_end) begin
						if (full) begin
							filled_q <= 1'b0;
							mat_q    <= '0;
							ovf_q    <= 1'b1;
						end else begin
							filled_q <= 1'b1;
							mat_q    <= nfe_q[IDX_W-1:0];
							ovf_q    <= 1'b0;
							nfe_q    <= nfe_q + NFE_W'(1);
						end
						state_q <= S_DONE;
					end else begin
						v_s1 <= issue;
						if (issue) begin
							idx_s1 <= idx_q[IDX_W-1:0];
							idx_q  <= idx_q + NFE_W'(1);
						end
					end
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		rsp.done    = state_q == S_DONE;
		rsp.filled  = filled_q;
		rsp.mat     = mat_q;
		rsp.ovf_set = ovf_q;
	end

endmodule

FILE: rtl/voxel_color_palette_indexer_top.sv
// An accepted voxel beat whose colour is empty, or that follows an overflow, skips the palette
// search; any other beat scans the palette entries filled so far before its result is registered.
// The palette search reads one stored colour per cycle through a single memory read port and
// compares it in one 32-bit comparator, so the next voxel is taken once this one's result is
// registered. Reset clears the control state, the position counter and the overflow flag, and sets
// the fill count to one; the palette stays undefined.
module voxel_color_palette_indexer_top
	import vcpi_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	vcpi_in_if.sink           vox,
	vcpi_out_if.source        res
);

	logic             bgra_q;
	logic             busy_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_item_q;
	logic             ovf_q;

	logic             out_valid_q;
	logic             filled_q;
	logic [MAT_W-1:0] mat_q;
	logic [POS_W-1:0] pos_out_q;
	logic             ovf_out_q;

	logic                     accept;
	logic                     take;
	logic [POS_W-1:0]         pos_cur;
	logic                     ovf_cur;
	logic [IDX_W+MAT_W-1:0]   mat_wide;
	vcpi_req_t                req;
	vcpi_rsp_t                rsp;

	always_comb begin
		accept    = vox.valid && !busy_q;
		take      = rsp.done && (!out_valid_q || res.ready);
		pos_cur   = vox.matrix_start ? '0 : pos_q;
		ovf_cur   = vox.matrix_start ? 1'b0 : ovf_q;
		req.color = bgra_q ? to_rgba(vox.voxel_color) : vox.voxel_color;
		req.start = vox.matrix_start;
		req.skip  = (vox.voxel_color[31:24] == 8'd0) || ovf_cur;
		mat_wide  = {{MAT_W{1'b0}}, rsp.mat};
	end

	vcpi_search u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (accept),
		.req       (req),
		.take      (take),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bgra_q      <= 1'b0;
			busy_q      <= 1'b0;
			pos_q       <= '0;
			pos_item_q  <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			filled_q    <= 1'b0;
			mat_q       <= '0;
			pos_out_q   <= '0;
			ovf_out_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				bgra_q <= cfg_wdata;
			end
			if (accept) begin
				busy_q     <= 1'b1;
				pos_item_q <= pos_cur;
				pos_q      <= (pos_cur == POS_MAX) ? pos_cur : pos_cur + POS_W'(1);
				ovf_q      <= ovf_cur;
			end
			if (take) begin
				busy_q      <= 1'b0;
				out_valid_q <= 1'b1;
				filled_q    <= rsp.filled;
				mat_q       <= mat_wide[MAT_W-1:0];
				pos_out_q   <= pos_item_q;
				ovf_out_q   <= ovf_q | rsp.ovf_set;
				ovf_q       <= ovf_q | rsp.ovf_set;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign vox.ready            = !busy_q;
	assign res.valid            = out_valid_q;
	assign res.voxel_filled     = filled_q;
	assign res.material_index   = mat_q;
	assign res.voxel_position   = pos_out_q;
	assign res.palette_overflow = ovf_out_q;

endmodule

FILE: verif/vcpi_result_checker.sv
module vcpi_result_checker
	import vcpi_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic cfg_wdata,
	vcpi_in_if   vox,
	vcpi_out_if  res,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             filled;
		logic [MAT_W-1:0] mat;
		logic [POS_W-1:0] pos;
		logic             ovf;
	} voxel_result_t;

	logic [COLOR_W-1:0] palette [PALETTE_DEPTH];
	int unsigned        fill_next;
	logic [POS_W-1:0]   pos_count;
	logic               ovf_flag;
	logic               bgra;
	voxel_result_t      expected_results [$];
	int                 fail_count = 0;

	assign errors  = fail_count;
	assign pending = expected_results.size();

	function automatic voxel_result_t index_voxel(input logic [COLOR_W-1:0] color_in,
		input logic start);
		voxel_result_t      r;
		logic [COLOR_W-1:0] c;
		int unsigned        i;
		int unsigned        lim;
		bit                 hit;
		if (start) begin
			fill_next = 1;
			pos_count = '0;
			ovf_flag  = 1'b0;
		end
		r     = '0;
		r.pos = pos_count;
		if (pos_count != POS_MAX) begin
			pos_count = pos_count + 1'b1;
		end
		if (color_in[31:24] != 8'h00 && !ovf_flag) begin
			c   = bgra ? {color_in[31:24], color_in[7:0], color_in[15:8], color_in[23:16]}
				: color_in;
			lim = (fill_next > PALETTE_DEPTH) ? PALETTE_DEPTH : fill_next;
			hit = 1'b0;
			for (i = 1; i < lim; i++) begin
				if (palette[i] == c) begin
					hit = 1'b1;
					break;
				end
			end
			if (hit) begin
				r.filled = 1'b1;
				r.mat    = MAT_W'(i);
			end else if (fill_next >= PALETTE_DEPTH) begin
				ovf_flag = 1'b1;
			end else begin
				palette[fill_next] = c;
				r.mat              = MAT_W'(fill_next);
				r.filled           = 1'b1;
				fill_next++;
			end
		end
		r.ovf = ovf_flag;
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		voxel_result_t want;
		if (!arst_n) begin
			fill_next = 1;
			pos_count = '0;
			ovf_flag  = 1'b0;
			bgra      = 1'b0;
			expected_results.delete();
		end else begin
			if (cfg_we) begin
				bgra = cfg_wdata;
			end
			if (vox.valid && vox.ready) begin
				expected_results.push_back(index_voxel(vox.voxel_color, vox.matrix_start));
			end
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					$error("Result beat arrived with no voxel waiting for one.");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("voxel_filled", 32'(want.filled), 32'(res.voxel_filled));
					compare_field("material_index", 32'(want.mat), 32'(res.material_index));
					compare_field("voxel_position", 32'(want.pos), 32'(res.voxel_position));
					compare_field("palette_overflow", 32'(want.ovf),
						32'(res.palette_overflow));
				end
			end
		end
	end

endmodule

FILE: verif/tb_voxel_color_palette_indexer_top.sv
module tb_voxel_color_palette_indexer_top;
	import vcpi_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RUN_ITEMS   = 1100;
	localparam int CYCLE_LIMIT = 2_000_000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	bit          no_gaps = 1'b0;
	int          mismatches;
	int          in_flight;
	int unsigned cycle_count = 0;

	vcpi_in_if  vox ();
	vcpi_out_if res ();

	voxel_color_palette_indexer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.vox       (vox),
		.res       (res)
	);

	vcpi_result_checker result_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.vox       (vox),
		.res       (res),
		.errors    (mismatches),
		.pending   (in_flight)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [31:0] solid_color();
		logic [31:0] c;
		c = $urandom;
		if (c[31:24] == 8'h00) begin
			c[31:24] = 8'h01;
		end
		return c;
	endfunction

	// Called at a rising edge; returns at the edge on which the beat is taken.
	task automatic send_voxel(input logic [31:0] color, input logic start);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			vox.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vox.valid        <= 1'b1;
		vox.voxel_color  <= color;
		vox.matrix_start <= start;
		@(posedge clk);
		while (!vox.ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		vox.valid <= 1'b0;
		do @(negedge clk); while (in_flight != 0);
		@(posedge clk);
	endtask

	task automatic write_bgra(input logic value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int gap;
		res.ready <= 1'b0;
		repeat (10) @(posedge clk);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 8);
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (!res.valid) @(posedge clk);
		end
	end

	initial begin
		logic [31:0] pool [16];
		logic [31:0] color;
		int          sent;
		int          len;
		int          npool;
		int          roll;
		bit          fill_kind;
		bit          first_matrix;
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_wdata        <= 1'b0;
		vox.valid        <= 1'b0;
		vox.voxel_color  <= '0;
		vox.matrix_start <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Voxels before any matrix start run on the reset state.
		send_voxel(32'h8011_2233, 1'b0);
		send_voxel(32'h00FF_FFFF, 1'b0);
		send_voxel(32'hFF00_0000, 1'b1);
		send_voxel(32'hFFFF_FFFF, 1'b0);
		send_voxel(32'hFF00_0000, 1'b0);
		send_voxel(32'h0000_0000, 1'b0);
		send_voxel(32'h01AB_CDEF, 1'b0);
		send_voxel(32'hFFFF_FFFF, 1'b0);

		write_bgra(1'b1);
		send_voxel(32'h4010_2030, 1'b1);
		send_voxel(32'h4030_2010, 1'b0);
		send_voxel(32'h4010_2030, 1'b0);
		send_voxel(32'h0010_2030, 1'b0);

		write_bgra(1'b0);
		send_voxel(32'h4030_2010, 1'b0);
		send_voxel(32'h4010_2030, 1'b0);
		send_voxel(32'h0000_0000, 1'b1);
		send_voxel(32'h7F00_FF00, 1'b0);

		// Each random matrix opens with a start beat; the first one overruns the palette.
		sent         = 0;
		first_matrix = 1'b1;
		while (sent < RUN_ITEMS) begin
			if ($urandom_range(0, 3) == 0) begin
				write_bgra(1'($urandom_range(0, 1)));
			end
			no_gaps   = ($urandom_range(0, 3) == 0);
			fill_kind = first_matrix || ($urandom_range(0, 9) == 0);
			first_matrix = 1'b0;
			len   = fill_kind ? PALETTE_DEPTH + 64 : $urandom_range(1, 40);
			npool = $urandom_range(1, 12);
			for (int p = 0; p < npool; p++) begin
				pool[p] = solid_color();
			end
			for (int k = 0; k < len && sent < RUN_ITEMS; k++) begin
				roll = $urandom_range(0, 15);
				if (roll == 0) begin
					color = {8'h00, 24'($urandom)};
				end else if (fill_kind ? roll != 1 : roll < 4) begin
					color = solid_color();
				end else begin
					color = pool[$urandom_range(0, npool - 1)];
				end
				send_voxel(color, (k == 0) || (!fill_kind && $urandom_range(0, 60) == 0));
				sent++;
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
